// ===== rtl/assert_macros.svh =====
// Assertion helpers included by the table unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an expression never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== rtl/mest_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mest_pkg
// Types and codes shared by the match event supersede table.
// ----------------------------------------------------------------------------
package mest_pkg;

    localparam logic [1:0] BIND_CONTENT = 2'd0;
    localparam logic [1:0] BIND_SUCC    = 2'd1;
    localparam logic [1:0] BIND_PRED    = 2'd2;

    localparam logic [15:0] LEN_ERROR = 16'hFFFF;

    // One stored match.
    typedef struct packed {
        logic [15:0] len;
        logic [31:0] pos;
        logic [1:0]  binding;
        logic [7:0]  level;
        logic [29:0] id;
    } entry_t;

    // The match being added, as the compare unit sees it.
    typedef struct packed {
        logic [29:0] pid;
        logic [7:0]  level;
        logic [31:0] pos;
        logic [32:0] end_pos;
    } event_t;

    // Compare results of one stored entry against the event.
    typedef struct packed {
        logic pos_lt;
        logic pos_gt;
        logic end_lt;
        logic del_hit;
        logic cover_hit;
    } match_flags_t;

    // One flush result before the sticky flags join it.
    typedef struct packed {
        logic [29:0] id;
        logic [6:0]  ordinal;
        logic [31:0] pos;
        logic [15:0] len;
        logic        empty;
    } result_t;

endpackage

// ===== rtl/match_event_supersede_table_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// match_event_supersede_table_unit
// Position-sorted match table with superseding on add and ordinal flush.
// ----------------------------------------------------------------------------
// An add walks the table in up to three passes over the entry RAM, with a
//   read-issue state and a compare state per entry visited; an oversize add
//   is flagged and dropped. A flush scans up to the first content entry,
//   then walks the whole table, a read and a check state per entry, plus a
//   push state per result handed on, which waits on result stalls.
// Throughput is set by the single read port of the entry RAM.
// Reset clears count, flags and control; RAM contents are left as they are.
`include "assert_macros.svh"

module match_event_supersede_table_unit #(
    parameter int ENTRIES = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pattern_id[29:0] alt_id[59:30] level[67:60] bind_req[69:68]
    // start_pos[101:70] match_len[117:102], zero pad above
    input  logic [119:0] s_tdata,
    // mode[0]
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // lexeme_id[29:0] ordinal[36:30] out_pos[68:37] out_len[84:69]
    // overflow[85] size_error[86], zero pad above
    output logic [87:0]  m_tdata,
    // empty_res[0]
    output logic         m_tuser,
    output logic         m_tlast
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_DS_RD, ST_DS_CHK, ST_CMP_RD, ST_CMP_CHK, ST_CV_RD, ST_CV_CHK,
        ST_CAP, ST_SH_RD, ST_SH_CHK, ST_INS, ST_INS2, ST_FF_RD, ST_FF_CHK,
        ST_FE_RD, ST_FE_CHK
    } state_t;

    typedef enum logic [1:0] {
        SUB_NONE, SUB_PUSH, SUB_FINAL, SUB_EMPTY
    } sub_t;

    state_t                 state_reg;
    sub_t                   sub_reg;
    logic [CW-1:0]          i_reg;
    logic [CW-1:0]          wp_reg;
    logic [CW-1:0]          f_reg;
    logic [CW-1:0]          count_reg;
    logic                   dels_reg;
    logic                   need2_reg;
    logic                   ovf_reg;
    logic                   sze_reg;
    logic [29:0]            alt_reg;
    logic [1:0]             bind_reg;
    logic [15:0]            len_reg;
    mest_pkg::event_t       ev_reg;
    logic [6:0]             ord_reg;
    logic [31:0]            last_pos_reg;
    mest_pkg::result_t      pend_reg;
    logic                   pend_valid_reg;
    mest_pkg::result_t      new_res_reg;
    mest_pkg::result_t      out_res_reg;
    logic                   out_ovf_reg;
    logic                   out_sze_reg;
    logic                   out_last_reg;
    logic                   out_valid_reg;

    mest_pkg::entry_t       rdata;
    mest_pkg::entry_t       wdata;
    mest_pkg::entry_t       new_ent;
    mest_pkg::match_flags_t mflags;
    logic                   we;
    logic [IW-1:0]          waddr;
    logic [IW-1:0]          raddr;
    logic [CW-1:0]          i_m1;
    logic [CW-1:0]          need_c;
    logic [CW:0]            cap_sum;
    logic                   out_free;
    logic                   out_load;
    logic                   emit_c;
    mest_pkg::result_t      res_c;
    logic [29:0]            s_pid;
    logic [29:0]            s_alt;
    logic [15:0]            s_len;
    logic [31:0]            s_pos;

    assign s_pid = s_tdata[29:0];
    assign s_alt = s_tdata[59:30];
    assign s_pos = s_tdata[101:70];
    assign s_len = s_tdata[117:102];

    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || m_tready;
    // a result moves into the output register this cycle
    assign out_load = (state_reg == ST_FE_CHK) && (sub_reg != SUB_NONE) && out_free;
    assign i_m1     = i_reg - CW'(1);
    assign need_c   = need2_reg ? CW'(2) : CW'(1);
    assign cap_sum  = {1'b0, count_reg} + {1'b0, need_c};

    assign new_ent.len     = len_reg;
    assign new_ent.pos     = ev_reg.pos;
    assign new_ent.binding = bind_reg;
    assign new_ent.level   = ev_reg.level;
    assign new_ent.id      = ev_reg.pid;

    mest_ram #(
        .WIDTH ($bits(mest_pkg::entry_t)),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    mest_match u_match (
        .ent   (rdata),
        .ev    (ev_reg),
        .flags (mflags)
    );

    // RAM port control: reads descend in the tail scans, ascend otherwise
    always_comb
    begin
        logic [CW-1:0] sh_addr;
        sh_addr = i_m1 + need_c;
        raddr   = i_reg[IW-1:0];
        we      = 1'b0;
        waddr   = wp_reg[IW-1:0];
        wdata   = rdata;
        case (state_reg)
            ST_DS_RD, ST_CV_RD, ST_SH_RD:
            begin
                raddr = i_m1[IW-1:0];
            end
            ST_CMP_CHK:
            begin
                // keep survivors, packed down toward the write pointer
                we = !mflags.del_hit;
            end
            ST_SH_CHK:
            begin
                we    = mflags.pos_gt;
                waddr = sh_addr[IW-1:0];
            end
            ST_INS:
            begin
                we    = 1'b1;
                waddr = i_reg[IW-1:0];
                wdata = new_ent;
            end
            ST_INS2:
            begin
                we       = 1'b1;
                waddr    = i_reg[IW-1:0];
                wdata    = new_ent;
                wdata.id = alt_reg;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    // Ordinal assignment for the flush emit pass
    always_comb
    begin
        res_c.id      = rdata.id;
        res_c.pos     = rdata.pos;
        res_c.len     = rdata.len;
        res_c.empty   = 1'b0;
        res_c.ordinal = 7'd1;
        emit_c        = 1'b0;
        if (i_reg < f_reg)
        begin
            emit_c = (rdata.binding == mest_pkg::BIND_SUCC);
        end
        else if (i_reg == f_reg)
        begin
            emit_c = 1'b1;
        end
        else
        begin
            case (rdata.binding)
                mest_pkg::BIND_CONTENT:
                begin
                    emit_c        = 1'b1;
                    res_c.ordinal = (rdata.pos > last_pos_reg) ? ord_reg + 7'd1 : ord_reg;
                end
                mest_pkg::BIND_SUCC:
                begin
                    emit_c        = 1'b1;
                    res_c.ordinal = ord_reg + 7'd1;
                end
                mest_pkg::BIND_PRED:
                begin
                    emit_c        = 1'b1;
                    res_c.ordinal = ord_reg;
                end
                default:
                begin
                    emit_c = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            sub_reg        <= SUB_NONE;
            i_reg          <= '0;
            wp_reg         <= '0;
            f_reg          <= '0;
            count_reg      <= '0;
            dels_reg       <= 1'b0;
            need2_reg      <= 1'b0;
            ovf_reg        <= 1'b0;
            sze_reg        <= 1'b0;
            ord_reg        <= '0;
            last_pos_reg   <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_tready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        ev_reg.pid     <= s_pid;
                        ev_reg.level   <= s_tdata[67:60];
                        ev_reg.pos     <= s_pos;
                        ev_reg.end_pos <= {1'b0, s_pos} + {17'b0, s_len};
                        alt_reg        <= s_alt;
                        bind_reg       <= s_tdata[69:68];
                        len_reg        <= s_len;
                        need2_reg      <= (s_alt != 30'd0) && (s_alt != s_pid);
                        dels_reg       <= 1'b0;
                        if (s_tuser)
                        begin
                            i_reg          <= '0;
                            pend_valid_reg <= 1'b0;
                            state_reg      <= ST_FF_RD;
                        end
                        else if (s_len == mest_pkg::LEN_ERROR)
                        begin
                            // oversize: flag and drop
                            sze_reg <= 1'b1;
                        end
                        else
                        begin
                            i_reg     <= count_reg;
                            state_reg <= ST_DS_RD;
                        end
                    end
                end
                ST_DS_RD:
                begin
                    if (i_reg == '0)
                    begin
                        if (dels_reg)
                        begin
                            wp_reg    <= '0;
                            state_reg <= ST_CMP_RD;
                        end
                        else
                        begin
                            i_reg     <= count_reg;
                            state_reg <= ST_CV_RD;
                        end
                    end
                    else
                    begin
                        state_reg <= ST_DS_CHK;
                    end
                end
                ST_DS_CHK:
                begin
                    if (mflags.pos_lt)
                    begin
                        // tail region starts at i; compact it or check cover
                        if (dels_reg)
                        begin
                            wp_reg    <= i_reg;
                            state_reg <= ST_CMP_RD;
                        end
                        else
                        begin
                            i_reg     <= count_reg;
                            state_reg <= ST_CV_RD;
                        end
                    end
                    else
                    begin
                        if (mflags.del_hit)
                        begin
                            dels_reg <= 1'b1;
                        end
                        i_reg     <= i_m1;
                        state_reg <= ST_DS_RD;
                    end
                end
                ST_CMP_RD:
                begin
                    if (i_reg == count_reg)
                    begin
                        count_reg <= wp_reg;
                        state_reg <= ST_CAP;
                    end
                    else
                    begin
                        state_reg <= ST_CMP_CHK;
                    end
                end
                ST_CMP_CHK:
                begin
                    if (!mflags.del_hit)
                    begin
                        wp_reg <= wp_reg + CW'(1);
                    end
                    i_reg     <= i_reg + CW'(1);
                    state_reg <= ST_CMP_RD;
                end
                ST_CV_RD:
                begin
                    state_reg <= (i_reg == '0) ? ST_CAP : ST_CV_CHK;
                end
                ST_CV_CHK:
                begin
                    if (mflags.end_lt)
                    begin
                        state_reg <= ST_CAP;
                    end
                    else if (mflags.cover_hit)
                    begin
                        // a higher level entry covers the event: drop it
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        i_reg     <= i_m1;
                        state_reg <= ST_CV_RD;
                    end
                end
                ST_CAP:
                begin
                    if (cap_sum > (CW + 1)'(ENTRIES))
                    begin
                        ovf_reg   <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        i_reg     <= count_reg;
                        state_reg <= ST_SH_RD;
                    end
                end
                ST_SH_RD:
                begin
                    state_reg <= (i_reg == '0) ? ST_INS : ST_SH_CHK;
                end
                ST_SH_CHK:
                begin
                    if (mflags.pos_gt)
                    begin
                        i_reg     <= i_m1;
                        state_reg <= ST_SH_RD;
                    end
                    else
                    begin
                        state_reg <= ST_INS;
                    end
                end
                ST_INS:
                begin
                    count_reg <= cap_sum[CW-1:0];
                    if (need2_reg)
                    begin
                        i_reg     <= i_reg + CW'(1);
                        state_reg <= ST_INS2;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_INS2:
                begin
                    state_reg <= ST_IDLE;
                end
                ST_FF_RD:
                begin
                    if (i_reg == count_reg)
                    begin
                        sub_reg   <= SUB_EMPTY;
                        state_reg <= ST_FE_CHK;
                    end
                    else
                    begin
                        state_reg <= ST_FF_CHK;
                    end
                end
                ST_FF_CHK:
                begin
                    if (rdata.binding == mest_pkg::BIND_CONTENT)
                    begin
                        f_reg     <= i_reg;
                        i_reg     <= '0;
                        state_reg <= ST_FE_RD;
                    end
                    else
                    begin
                        i_reg     <= i_reg + CW'(1);
                        state_reg <= ST_FF_RD;
                    end
                end
                ST_FE_RD:
                begin
                    if (i_reg == count_reg)
                    begin
                        sub_reg   <= SUB_FINAL;
                        state_reg <= ST_FE_CHK;
                    end
                    else
                    begin
                        sub_reg   <= SUB_NONE;
                        state_reg <= ST_FE_CHK;
                    end
                end
                ST_FE_CHK:
                begin
                    case (sub_reg)
                        SUB_NONE:
                        begin
                            if (i_reg == f_reg)
                            begin
                                ord_reg      <= 7'd1;
                                last_pos_reg <= rdata.pos;
                            end
                            else if ((i_reg > f_reg)
                                     && (rdata.binding == mest_pkg::BIND_CONTENT)
                                     && (rdata.pos > last_pos_reg))
                            begin
                                ord_reg      <= ord_reg + 7'd1;
                                last_pos_reg <= rdata.pos;
                            end
                            if (emit_c && pend_valid_reg)
                            begin
                                new_res_reg <= res_c;
                                sub_reg     <= SUB_PUSH;
                            end
                            else
                            begin
                                if (emit_c)
                                begin
                                    pend_reg       <= res_c;
                                    pend_valid_reg <= 1'b1;
                                end
                                i_reg     <= i_reg + CW'(1);
                                state_reg <= ST_FE_RD;
                            end
                        end
                        SUB_PUSH:
                        begin
                            // hand the held result on, hold the new one
                            if (out_free)
                            begin
                                out_res_reg   <= pend_reg;
                                out_ovf_reg   <= ovf_reg;
                                out_sze_reg   <= sze_reg;
                                out_last_reg  <= 1'b0;
                                out_valid_reg <= 1'b1;
                                pend_reg      <= new_res_reg;
                                i_reg         <= i_reg + CW'(1);
                                state_reg     <= ST_FE_RD;
                            end
                        end
                        default:
                        begin
                            // final result of the flush, then clear the table
                            if (out_free)
                            begin
                                if (sub_reg == SUB_EMPTY)
                                begin
                                    out_res_reg <= '{id: '0, ordinal: '0, pos: '0,
                                                     len: '0, empty: 1'b1};
                                end
                                else
                                begin
                                    out_res_reg <= pend_reg;
                                end
                                out_ovf_reg    <= ovf_reg;
                                out_sze_reg    <= sze_reg;
                                out_last_reg   <= 1'b1;
                                out_valid_reg  <= 1'b1;
                                pend_valid_reg <= 1'b0;
                                count_reg      <= '0;
                                ovf_reg        <= 1'b0;
                                sze_reg        <= 1'b0;
                                state_reg      <= ST_IDLE;
                            end
                        end
                    endcase
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_res_reg.empty;
    assign m_tdata  = {1'b0, out_sze_reg, out_ovf_reg, out_res_reg.len, out_res_reg.pos,
                       out_res_reg.ordinal, out_res_reg.id};

    `ASSERT_NEVER(a_count_bound, clk, rst_n, count_reg > CW'(ENTRIES),
        "entry count above table size")
    `ASSERT_CLK(a_final_has_pend, clk, rst_n,
        (state_reg == ST_FE_CHK && sub_reg == SUB_FINAL) |-> pend_valid_reg,
        "flush end without a held result")
    `ASSERT_CLK(a_flush_clears, clk, rst_n,
        (state_reg == ST_FE_CHK && (sub_reg == SUB_FINAL || sub_reg == SUB_EMPTY) && out_free)
        |=> (count_reg == '0 && !ovf_reg && !sze_reg && m_tlast),
        "flush did not clear the table")
    `ASSERT_NEVER(a_compact_order, clk, rst_n,
        state_reg == ST_CMP_CHK && wp_reg > i_reg,
        "compaction write ahead of read")

endmodule

// ===== rtl/mest_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mest_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mest_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/mest_match.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mest_match
// Compare one stored entry against the event being added.
// ----------------------------------------------------------------------------
module mest_match (
    input  mest_pkg::entry_t       ent,
    input  mest_pkg::event_t       ev,
    output mest_pkg::match_flags_t flags
);

    logic [32:0] ent_end;

    always_comb
    begin
        ent_end         = {1'b0, ent.pos} + {17'b0, ent.len};
        flags.pos_lt    = ent.pos < ev.pos;
        flags.pos_gt    = ent.pos > ev.pos;
        flags.end_lt    = ent_end < ev.end_pos;
        // duplicate, or a lower level entry that the event covers
        flags.del_hit   = ((ent.id == ev.pid) && (ent.pos == ev.pos) && (ent.level == ev.level))
                          || ((ent.level < ev.level) && (ent_end <= ev.end_pos));
        flags.cover_hit = (ent.level > ev.level) && !(ent.pos > ev.pos);
    end

endmodule
